// ===== hw/rtl/cc20_pkg.sv =====
// ChaCha20 stream XOR: shared types, constants and helper functions.
// No dependencies; used by every module under hw/rtl.
`timescale 1ns / 1ps
package cc20_pkg;

  localparam int DoubleRounds = 10;
  localparam int RoundBits    = 5;   // counts 0 .. 2*DoubleRounds-1

  localparam logic [31:0] Sigma0 = 32'h61707865;
  localparam logic [31:0] Sigma1 = 32'h3320646e;
  localparam logic [31:0] Sigma2 = 32'h79622d32;
  localparam logic [31:0] Sigma3 = 32'h6b206574;

  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 64;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_KEY_A    = 3'd0,
    CFG_KEY_B    = 3'd1,
    CFG_KEY_C    = 3'd2,
    CFG_KEY_D    = 3'd3,
    CFG_NONCE_LO = 3'd4,
    CFG_NONCE_HI = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic       end_of_message;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    logic       end_of_message_out;
    logic [7:0] cipher_byte;
  } out_word_t;

  typedef logic [15:0][31:0] state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH,
    ST_STREAM
  } ctl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch initial state from key, nonce, counter
    logic round;     // run one half round (column or diagonal)
    logic diag;      // half round is diagonal
    logic finish;    // add input words back
    logic consume;   // emit one byte
    logic restart;   // end of message: counter and position to zero
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_byte; // position 63
  } dp_sts_t;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    rotl32 = (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [127:0] qround(input logic [31:0] a, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] ta, tb, tc, td;
    ta = a + b;   td = rotl32(d ^ ta, 16);
    tc = c + td;  tb = rotl32(b ^ tc, 12);
    ta = ta + tb; td = rotl32(td ^ ta, 8);
    tc = tc + td; tb = rotl32(tb ^ tc, 7);
    qround = {ta, tb, tc, td};
  endfunction

endpackage

// ===== hw/rtl/chacha20_stream_xor.sv =====
// ChaCha20 (IETF) stream XOR, top level: controller plus datapath.
// Depends on cc20_pkg, cc20_ctrl, cc20_dp.
//
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------
//  in        | in_valid/in_stall  | in_word  (data_byte, end_of_message)
//  out       | out_valid/out_stall| out_word (cipher_byte, end_of_message_out)
//  cfg       | cfg_write          | cfg_index, cfg_data (64 bits)
//
// A word is passed straight through while a keystream block is on hand. The first
// word of each block waits for block generation: a load step, 20 half
// rounds on one shared four-quarter-round unit and an add-back step, so
// the wait comes every 64 words and at each message start.
// Reset (rst, synchronous) clears key, nonce, counter, position and control
// state, drops any block. Out stall holds the output register, stalls in.
`timescale 1ns / 1ps
module chacha20_stream_xor (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [cc20_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [cc20_pkg::CfgDataBits-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cc20_pkg::in_word_t              in_word,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cc20_pkg::out_word_t             out_word
);
  import cc20_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing of block generation and word acceptance
  cc20_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_last   (in_word.end_of_message),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // key schedule state, rounds and byte XOR
  cc20_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_word),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTH
  // an accepted word shows up at the output next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted word not presented");

  // rounds and byte output never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(cmd.consume && (cmd.round || cmd.load || cmd.finish)))
    else $error("round unit busy while streaming");

  // a word is only taken when the output register can hold it
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !cmd.consume)
    else $error("output register overrun");
`endif
endmodule

// ===== hw/rtl/cc20_ctrl.sv =====
// ChaCha20 stream XOR: controller state machine.
// Uses cc20_pkg; drives the datapath by dp_cmd_t, reads dp_sts_t.
`timescale 1ns / 1ps
module cc20_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_last,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cc20_pkg::dp_cmd_t    cmd,
  input  cc20_pkg::dp_sts_t    sts
);
  import cc20_pkg::*;

  ctl_state_t               state, state_next;
  logic [RoundBits-1:0]     rnd, rnd_next;
  logic                     ready, ready_next;   // keystream block valid
  logic                     ovalid, ovalid_next;
  logic                     take;

  // output register is free, or being emptied this cycle
  logic oreg_free;
  assign oreg_free = !ovalid || !out_stall;
  assign out_valid = ovalid;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid && !ready) state_next = ST_ROUND;
                 else if (ready) state_next = ST_STREAM;
      ST_ROUND:  if (rnd == RoundBits'(2*DoubleRounds-1)) state_next = ST_FINISH;
      ST_FINISH: state_next = ST_STREAM;
      ST_STREAM: if (take && (in_last || sts.last_byte)) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_stall   = 1'b1;
    take       = 1'b0;
    rnd_next   = rnd;
    ready_next = ready;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !ready) begin
          cmd.load = 1'b1;
          rnd_next = '0;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.diag  = rnd[0];
        rnd_next  = rnd + 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        ready_next = 1'b1;
      end
      ST_STREAM: begin
        in_stall = !oreg_free;
        take     = in_valid && oreg_free;
        if (take) begin
          cmd.consume = 1'b1;
          cmd.restart = in_last;
          if (in_last || sts.last_byte) ready_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ovalid_next = ovalid;
    if (!out_stall) ovalid_next = 1'b0;
    if (take) ovalid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rnd    <= '0;
      ready  <= 1'b0;
      ovalid <= 1'b0;
    end else begin
      state  <= state_next;
      rnd    <= rnd_next;
      ready  <= ready_next;
      ovalid <= ovalid_next;
    end
  end
endmodule

// ===== hw/rtl/cc20_dp.sv =====
// ChaCha20 stream XOR: datapath with configuration registers, round unit,
// keystream block, counter, byte position and output register. Uses cc20_pkg.
`timescale 1ns / 1ps
module cc20_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [cc20_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [cc20_pkg::CfgDataBits-1:0] cfg_data,
  input  cc20_pkg::in_word_t            in_word,
  output cc20_pkg::out_word_t           out_word,
  input  cc20_pkg::dp_cmd_t             cmd,
  output cc20_pkg::dp_sts_t             sts
);
  import cc20_pkg::*;

  logic [63:0] key_a, key_b, key_c, key_d, nonce_lo;
  logic [31:0] nonce_hi;
  logic [31:0] counter;
  logic [5:0]  pos;
  state_t      init, work, ks;
  out_word_t   oreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_a <= '0; key_b <= '0; key_c <= '0; key_d <= '0;
      nonce_lo <= '0; nonce_hi <= '0;
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY_A:    key_a    <= cfg_data;
        CFG_KEY_B:    key_b    <= cfg_data;
        CFG_KEY_C:    key_c    <= cfg_data;
        CFG_KEY_D:    key_d    <= cfg_data;
        CFG_NONCE_LO: nonce_lo <= cfg_data;
        CFG_NONCE_HI: nonce_hi <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // one half round: four quarter rounds side by side
  state_t half;
  always_comb begin
    logic [127:0] q0, q1, q2, q3;
    half = work;
    if (!cmd.diag) begin
      q0 = qround(work[0], work[4], work[8],  work[12]);
      q1 = qround(work[1], work[5], work[9],  work[13]);
      q2 = qround(work[2], work[6], work[10], work[14]);
      q3 = qround(work[3], work[7], work[11], work[15]);
      {half[0], half[4], half[8],  half[12]} = q0;
      {half[1], half[5], half[9],  half[13]} = q1;
      {half[2], half[6], half[10], half[14]} = q2;
      {half[3], half[7], half[11], half[15]} = q3;
    end else begin
      q0 = qround(work[0], work[5], work[10], work[15]);
      q1 = qround(work[1], work[6], work[11], work[12]);
      q2 = qround(work[2], work[7], work[8],  work[13]);
      q3 = qround(work[3], work[4], work[9],  work[14]);
      {half[0], half[5], half[10], half[15]} = q0;
      {half[1], half[6], half[11], half[12]} = q1;
      {half[2], half[7], half[8],  half[13]} = q2;
      {half[3], half[4], half[9],  half[14]} = q3;
    end
  end

  state_t load_val;
  always_comb begin
    load_val[0]  = Sigma0;
    load_val[1]  = Sigma1;
    load_val[2]  = Sigma2;
    load_val[3]  = Sigma3;
    load_val[4]  = key_a[31:0];    load_val[5]  = key_a[63:32];
    load_val[6]  = key_b[31:0];    load_val[7]  = key_b[63:32];
    load_val[8]  = key_c[31:0];    load_val[9]  = key_c[63:32];
    load_val[10] = key_d[31:0];    load_val[11] = key_d[63:32];
    load_val[12] = counter;
    load_val[13] = nonce_lo[31:0]; load_val[14] = nonce_lo[63:32];
    load_val[15] = nonce_hi;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      init <= load_val;
      work <= load_val;
    end else if (cmd.round) begin
      work <= half;
    end
    if (cmd.finish) begin
      for (int i = 0; i < 16; i++) ks[i] <= work[i] + init[i];
    end
  end

  logic [31:0] ks_word;
  logic [7:0]  ks_byte;
  assign ks_word = ks[pos[5:2]];
  assign ks_byte = ks_word[pos[1:0]*8 +: 8];

  always_ff @(posedge clk) begin
    if (rst) begin
      counter <= '0;
      pos     <= '0;
    end else if (cmd.consume) begin
      if (cmd.restart) begin
        counter <= '0;
        pos     <= '0;
      end else begin
        pos <= pos + 1'b1;
        if (pos == 6'd63) counter <= counter + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.consume) begin
      oreg.cipher_byte        <= in_word.data_byte ^ ks_byte;
      oreg.end_of_message_out <= in_word.end_of_message;
    end
  end

  assign out_word      = oreg;
  assign sts.last_byte = (pos == 6'd63);
endmodule
